// ===== src/pidta_pkg.sv =====
// Shared types, register indexes and saturation helpers for the PID controller.
`default_nettype none
package pidta_pkg;

	localparam int RegIdxW = 4;

	typedef enum logic [RegIdxW-1:0] {
		REG_GAIN_P      = 4'd0,
		REG_GAIN_I      = 4'd1,
		REG_GAIN_D      = 4'd2,
		REG_STEP_TIME   = 4'd3,
		REG_OUT_UPPER   = 4'd4,
		REG_OUT_LOWER   = 4'd5,
		REG_INTEG_UPPER = 4'd6,
		REG_INTEG_LOWER = 4'd7
	} reg_idx_t;

	// Request to the shared multiplier: full product a*b, returned as floor(a*b / 2^16)
	typedef struct packed {
		logic              go;
		logic signed [47:0] a;
		logic signed [32:0] b;
	} mul_req_t;

	// Request to the shared divider: num / den, truncated toward zero
	typedef struct packed {
		logic              go;
		logic signed [48:0] num;
		logic signed [32:0] den;
	} div_req_t;

	function automatic logic signed [31:0] sat_to32(input logic signed [49:0] x);
		logic signed [31:0] r;
		if ((&x[49:31]) || !(|x[49:31])) begin
			r = x[31:0];
		end else if (x[49]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

	function automatic logic signed [47:0] sat_to48(input logic signed [49:0] x);
		logic signed [47:0] r;
		if ((&x[49:47]) || !(|x[49:47])) begin
			r = x[47:0];
		end else if (x[49]) begin
			r = 48'sh8000_0000_0000;
		end else begin
			r = 48'sh7FFF_FFFF_FFFF;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/pidta_sample_if.sv =====
// Input channel carrying one error sample per transaction.
`default_nettype none
interface pidta_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] error_sample;

	modport source (output valid, output error_sample, input ready);
	modport sink (input valid, input error_sample, output ready);
endinterface
`default_nettype wire

// ===== src/pidta_result_if.sv =====
// Output channel carrying the clamped drive value and its saturation flag.
`default_nettype none
interface pidta_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive;
	logic               saturated;

	modport source (output valid, output drive, output saturated, input ready);
	modport sink (input valid, input drive, input saturated, output ready);
endinterface
`default_nettype wire

// ===== src/pidta_mul.sv =====
// Shared 48x33 signed multiplier built from two 25x33 partial products.
`default_nettype none
module pidta_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pidta_pkg::mul_req_t req,
	output logic                    done,
	output logic signed [64:0]      result
);

	typedef enum logic [1:0] {
		MUL_IDLE,
		MUL_LO,
		MUL_HI,
		MUL_ADD
	} mul_state_t;

	mul_state_t         state_q;
	logic signed [47:0] a_q;
	logic signed [32:0] b_q;
	logic signed [24:0] mx;
	logic signed [57:0] prod_q;
	logic signed [80:0] acc_q;
	logic               done_q;

	// low 24 bits go in unsigned, the upper part signed and weighted by 2^24
	assign mx = (state_q == MUL_LO) ? $signed({1'b0, a_q[23:0]})
		: $signed({a_q[47], a_q[47:24]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MUL_IDLE;
			a_q     <= '0;
			b_q     <= '0;
			prod_q  <= '0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MUL_IDLE: begin
					if (req.go) begin
						a_q     <= $signed(req.a);
						b_q     <= $signed(req.b);
						state_q <= MUL_LO;
					end
				end
				MUL_LO: begin
					prod_q  <= mx * b_q;
					state_q <= MUL_HI;
				end
				MUL_HI: begin
					acc_q   <= 81'(prod_q);
					prod_q  <= mx * b_q;
					state_q <= MUL_ADD;
				end
				MUL_ADD: begin
					acc_q   <= acc_q + (81'(prod_q) <<< 24);
					done_q  <= 1'b1;
					state_q <= MUL_IDLE;
				end
				default: begin
					state_q <= MUL_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	// arithmetic shift by 16 is the floor of the Q16.16 rescale
	assign result = $signed(acc_q[80:16]);

endmodule
`default_nettype wire

// ===== src/pidta_div.sv =====
// Shared restoring divider, one quotient bit per cycle, signed truncating result.
`default_nettype none
module pidta_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pidta_pkg::div_req_t req,
	output logic                    done,
	output logic signed [49:0]      quotient
);

	localparam int DivSteps = 49;
	localparam int CntW     = $clog2(DivSteps + 1);

	logic                busy_q;
	logic                done_q;
	logic                neg_q;
	logic [CntW-1:0]     cnt_q;
	logic [31:0]         dmag_q;
	logic [31:0]         rem_q;
	logic [48:0]         nq_q;
	logic [48:0]         num_mag;
	logic [32:0]         den_neg;
	logic [32:0]         trial;
	logic [32:0]         diff;
	logic                ge;

	assign num_mag = req.num[48] ? (~req.num + 49'd1) : req.num;
	assign den_neg = ~req.den + 33'd1;
	assign trial   = {rem_q, nq_q[48]};
	assign diff    = trial - {1'b0, dmag_q};
	assign ge      = (trial >= {1'b0, dmag_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			dmag_q <= '0;
			rem_q  <= '0;
			nq_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				// remainder stays below the divisor, so 32 bits hold it
				rem_q <= ge ? diff[31:0] : trial[31:0];
				nq_q  <= {nq_q[47:0], ge};
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.go) begin
				busy_q <= 1'b1;
				neg_q  <= req.num[48] ^ req.den[32];
				dmag_q <= req.den[32] ? den_neg[31:0] : req.den[31:0];
				nq_q   <= num_mag;
				rem_q  <= '0;
				cnt_q  <= CntW'(DivSteps);
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, nq_q}) : $signed({1'b0, nq_q});

endmodule
`default_nettype wire

// ===== src/pid_controller_trapezoid_antiwindup.sv =====
// PID controller, trapezoid integral with anti-windup, sequenced over a shared mul and divider.
// Each sample takes four multiplies and one divide; at zero step time the derivative divide and
// multiply are skipped. Each automatic integral clamp that fires adds a divide and a multiply.
// A sample is taken only after the last result is registered; the 49-step divide is the slowest part.
// Reset: arst_n clears gains to zero, step time to 1.0, output limits to full range, integral
// limits, state to zero. Register writes clear integral and previous error unless the FSM updates them.
`default_nettype none
module pid_controller_trapezoid_antiwindup (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [pidta_pkg::RegIdxW-1:0]     wr_index,
	input  wire logic [31:0]                       wr_data,
	pidta_sample_if.sink                           sample,
	pidta_result_if.source                         result
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P_MUL,
		ST_D_DIV,
		ST_D_MUL,
		ST_INC_MUL,
		ST_CLAMP,
		ST_I_MUL,
		ST_LIM_DIV,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		CHK_HI,
		CHK_LO,
		CHK_NONE
	} chk_t;

	localparam logic [pidta_pkg::RegIdxW-1:0] RegCount = pidta_pkg::RegIdxW'(8);

	state_t             state_q;
	chk_t               phase_q;

	logic signed [31:0] gp_q;
	logic signed [31:0] gi_q;
	logic signed [31:0] gd_q;
	logic [30:0]        st_q;
	logic signed [31:0] ou_q;
	logic signed [31:0] ol_q;
	logic signed [31:0] iu_q;
	logic signed [31:0] il_q;

	logic signed [31:0] e_q;
	logic signed [31:0] last_q;
	logic signed [47:0] integ_q;
	logic signed [47:0] p_q;
	logic signed [47:0] d_q;
	logic signed [64:0] i_q;
	logic signed [65:0] total_q;

	logic               out_valid_q;
	logic signed [31:0] drive_q;
	logic               sat_q;

	pidta_pkg::mul_req_t mul_req_q;
	pidta_pkg::div_req_t div_req_q;
	logic                mul_done;
	logic signed [64:0]  mul_res;
	logic                div_done;
	logic signed [49:0]  div_quo;

	logic signed [32:0] err_sum;
	logic signed [32:0] err_diff;
	logic signed [31:0] deriv;
	logic signed [47:0] inc;
	logic signed [48:0] integ_sum;
	logic signed [47:0] clamp_hi;
	logic signed [47:0] clamp_val;
	logic signed [47:0] lim_val;
	logic               auto_mode;
	logic               auto_ok;
	logic               hi_fire;
	logic               lo_fire;
	logic               tot_hi;
	logic               tot_lo;
	logic signed [65:0] tot_upper;
	logic signed [31:0] drive_next;

	pidta_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.done   (mul_done),
		.result (mul_res)
	);

	pidta_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign err_sum   = 33'(e_q) + 33'(last_q);
	assign err_diff  = 33'(e_q) - 33'(last_q);
	assign deriv     = pidta_pkg::sat_to32(div_quo);
	// floor of the extra halving of the trapezoid
	assign inc       = mul_res[48:1];
	assign integ_sum = 49'(integ_q) + 49'(inc);
	assign lim_val   = pidta_pkg::sat_to48(div_quo);

	// explicit limits: upper first, then lower, so lower wins when they cross
	assign clamp_hi  = (integ_q > 48'(iu_q)) ? 48'(iu_q) : integ_q;
	assign clamp_val = (clamp_hi < 48'(il_q)) ? 48'(il_q) : clamp_hi;

	assign auto_mode = (iu_q == 32'sd0) && (il_q == 32'sd0);
	assign auto_ok   = auto_mode && (gi_q != 32'sd0);
	assign hi_fire   = (phase_q == CHK_HI) && auto_ok && (mul_res > ou_q);
	assign lo_fire   = !hi_fire && (phase_q != CHK_NONE) && auto_ok && (mul_res < ol_q);

	assign tot_hi     = (total_q > 66'(ou_q));
	assign tot_upper  = tot_hi ? 66'(ou_q) : total_q;
	assign tot_lo     = (tot_upper < 66'(ol_q));
	assign drive_next = tot_lo ? ol_q : tot_upper[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= CHK_NONE;
			gp_q        <= '0;
			gi_q        <= '0;
			gd_q        <= '0;
			st_q        <= 31'd65536;
			ou_q        <= 32'sh7FFF_FFFF;
			ol_q        <= 32'sh8000_0000;
			iu_q        <= '0;
			il_q        <= '0;
			e_q         <= '0;
			last_q      <= '0;
			integ_q     <= '0;
			p_q         <= '0;
			d_q         <= '0;
			i_q         <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			sat_q       <= 1'b0;
			mul_req_q   <= '0;
			div_req_q   <= '0;
		end else begin
			mul_req_q.go <= 1'b0;
			div_req_q.go <= 1'b0;

			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (wr_en) begin
				case (pidta_pkg::reg_idx_t'(wr_index))
					pidta_pkg::REG_GAIN_P:      gp_q <= wr_data;
					pidta_pkg::REG_GAIN_I:      gi_q <= wr_data;
					pidta_pkg::REG_GAIN_D:      gd_q <= wr_data;
					pidta_pkg::REG_STEP_TIME:   st_q <= wr_data[30:0];
					pidta_pkg::REG_OUT_UPPER:   ou_q <= wr_data;
					pidta_pkg::REG_OUT_LOWER:   ol_q <= wr_data;
					pidta_pkg::REG_INTEG_UPPER: iu_q <= wr_data;
					pidta_pkg::REG_INTEG_LOWER: il_q <= wr_data;
					default: begin
					end
				endcase
				if (wr_index < RegCount) begin
					integ_q <= '0;
					last_q  <= '0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						e_q           <= sample.error_sample;
						mul_req_q.go  <= 1'b1;
						mul_req_q.a   <= 48'(sample.error_sample);
						mul_req_q.b   <= 33'(gp_q);
						state_q       <= ST_P_MUL;
					end
				end
				ST_P_MUL: begin
					if (mul_done) begin
						p_q <= mul_res[47:0];
						if (st_q != 31'd0) begin
							div_req_q.go  <= 1'b1;
							div_req_q.num <= {err_diff, 16'h0000};
							div_req_q.den <= {2'b00, st_q};
							state_q       <= ST_D_DIV;
						end else begin
							d_q          <= '0;
							mul_req_q.go <= 1'b1;
							mul_req_q.a  <= 48'(err_sum);
							mul_req_q.b  <= {2'b00, st_q};
							state_q      <= ST_INC_MUL;
						end
					end
				end
				ST_D_DIV: begin
					if (div_done) begin
						mul_req_q.go <= 1'b1;
						mul_req_q.a  <= 48'(deriv);
						mul_req_q.b  <= 33'(gd_q);
						state_q      <= ST_D_MUL;
					end
				end
				ST_D_MUL: begin
					if (mul_done) begin
						d_q          <= mul_res[47:0];
						mul_req_q.go <= 1'b1;
						mul_req_q.a  <= 48'(err_sum);
						mul_req_q.b  <= {2'b00, st_q};
						state_q      <= ST_INC_MUL;
					end
				end
				ST_INC_MUL: begin
					if (mul_done) begin
						integ_q <= pidta_pkg::sat_to48(50'(integ_sum));
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					mul_req_q.go <= 1'b1;
					mul_req_q.b  <= 33'(gi_q);
					if (auto_mode) begin
						mul_req_q.a <= integ_q;
						phase_q     <= CHK_HI;
					end else begin
						integ_q     <= clamp_val;
						mul_req_q.a <= clamp_val;
						phase_q     <= CHK_NONE;
					end
					state_q <= ST_I_MUL;
				end
				ST_I_MUL: begin
					if (mul_done) begin
						if (hi_fire) begin
							div_req_q.go  <= 1'b1;
							div_req_q.num <= {ou_q[31], ou_q, 16'h0000};
							div_req_q.den <= 33'(gi_q);
							phase_q       <= CHK_LO;
							state_q       <= ST_LIM_DIV;
						end else if (lo_fire) begin
							div_req_q.go  <= 1'b1;
							div_req_q.num <= {ol_q[31], ol_q, 16'h0000};
							div_req_q.den <= 33'(gi_q);
							phase_q       <= CHK_NONE;
							state_q       <= ST_LIM_DIV;
						end else begin
							i_q     <= mul_res;
							state_q <= ST_SUM;
						end
					end
				end
				ST_LIM_DIV: begin
					if (div_done) begin
						integ_q      <= lim_val;
						mul_req_q.go <= 1'b1;
						mul_req_q.a  <= lim_val;
						mul_req_q.b  <= 33'(gi_q);
						state_q      <= ST_I_MUL;
					end
				end
				ST_SUM: begin
					total_q <= 66'(p_q) + 66'(i_q) + 66'(d_q);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || result.ready) begin
						drive_q     <= drive_next;
						sat_q       <= tot_hi || tot_lo;
						out_valid_q <= 1'b1;
						last_q      <= e_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample.ready     = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.drive     = drive_q;
	assign result.saturated = sat_q;

endmodule
`default_nettype wire

// ===== src/pidta_chk.sv =====
// Port-level checker for the PID controller, bound to the top level.
`default_nettype none
module pidta_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_drive,
	input wire logic        out_sat
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_drive) && $stable(out_sat))
		else $error("result payload changed while stalled");

	// one sample in flight at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while a sample is being worked");

	// a result never follows its sample directly
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after the input transaction");

endmodule

bind pid_controller_trapezoid_antiwindup pidta_chk u_pidta_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_drive (result.drive),
	.out_sat   (result.saturated)
);
`default_nettype wire
